[src/pid_controller_clamped_defines.svh]
// Assertion macros shared by the PID controller checker.
`ifndef PID_CONTROLLER_CLAMPED_DEFINES_SVH
`define PID_CONTROLLER_CLAMPED_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define PCC_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define PCC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/pcc_pkg.sv]
// Package with types, widths and constants of the clamped PID controller.
`timescale 1ns / 1ps
`default_nettype none
package pcc_pkg;

   localparam int MODE_W      = 2;
   localparam int ERR_W       = 16;
   localparam int DRIVE_W     = 18;
   localparam int GAIN_W      = 16;
   localparam int ILIM_W      = 15;
   localparam int OLIM_W      = 17;
   localparam int CSR_DATA_W  = 17;
   localparam int CSR_INDEX_W = 3;

   typedef enum logic [MODE_W-1:0] {
      MODE_STEP   = 2'd0,
      MODE_CLEAR  = 2'd1,
      MODE_PRESET = 2'd2
   } mode_type;

   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_P         = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_I         = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_D         = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_INTEGRAL_LIMIT = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_OUTPUT_LIMIT   = 3'd4;

   localparam logic [GAIN_W-1:0] GAIN_P_RESET         = 16'd7168;
   localparam logic [GAIN_W-1:0] GAIN_I_RESET         = 16'd0;
   localparam logic [GAIN_W-1:0] GAIN_D_RESET         = 16'd44800;
   localparam logic [ILIM_W-1:0] INTEGRAL_LIMIT_RESET = 15'd25600;
   localparam logic [OLIM_W-1:0] OUTPUT_LIMIT_RESET   = 17'd128000;

   typedef struct packed {
      logic [GAIN_W-1:0] gain_p;
      logic [GAIN_W-1:0] gain_i;
      logic [GAIN_W-1:0] gain_d;
      logic [ILIM_W-1:0] integral_limit;
      logic [OLIM_W-1:0] output_limit;
   } cfg_type;

   typedef struct packed {
      logic signed [ERR_W-1:0]   integral;
      logic signed [ERR_W-1:0]   last_error;
      logic signed [DRIVE_W-1:0] drive;
   } pid_state_type;

endpackage
`default_nettype wire

[src/pcc_step.sv]
// Combinational next-state logic for one controller item.
`timescale 1ns / 1ps
`default_nettype none
module pcc_step (
   input  wire logic [pcc_pkg::MODE_W-1:0]         mode,
   input  wire logic signed [pcc_pkg::ERR_W-1:0]   error_in,
   input  wire logic signed [pcc_pkg::DRIVE_W-1:0] preset_drive,
   input  wire pcc_pkg::cfg_type                   cfg,
   input  wire pcc_pkg::pid_state_type             state_cur,
   output pcc_pkg::pid_state_type                  state_nxt
);
   import pcc_pkg::*;

   localparam int INT_SUM_W = ERR_W + 1;
   localparam int PROD_W    = 34;
   localparam int TERM_W    = PROD_W - 8;
   localparam int SUM_W     = TERM_W + 2;

   logic signed [INT_SUM_W-1:0] int_sum;
   logic signed [INT_SUM_W-1:0] ilim_pos;
   logic signed [INT_SUM_W-1:0] ilim_neg;
   logic signed [ERR_W-1:0]     int_clamped;
   logic signed [INT_SUM_W-1:0] err_diff;
   logic signed [PROD_W-1:0]    p_prod;
   logic signed [PROD_W-1:0]    i_prod;
   logic signed [PROD_W-1:0]    d_prod;
   logic signed [SUM_W-1:0]     pid_sum;
   logic signed [SUM_W-1:0]     olim_pos;
   logic signed [SUM_W-1:0]     olim_neg;
   logic signed [DRIVE_W-1:0]   drive_clamped;

   assign int_sum  = {state_cur.integral[ERR_W-1], state_cur.integral}
                   + {error_in[ERR_W-1], error_in};
   assign ilim_pos = {2'b00, cfg.integral_limit};
   assign ilim_neg = -ilim_pos;

   always_comb begin
      if (int_sum > ilim_pos) begin
         int_clamped = ilim_pos[ERR_W-1:0];
      end else if (int_sum < ilim_neg) begin
         int_clamped = ilim_neg[ERR_W-1:0];
      end else begin
         int_clamped = int_sum[ERR_W-1:0];
      end
   end

   assign err_diff = {error_in[ERR_W-1], error_in}
                   - {state_cur.last_error[ERR_W-1], state_cur.last_error};

   // Operands are extended to the product width, so each product is exact.
   assign p_prod = $signed({{(PROD_W-GAIN_W){1'b0}}, cfg.gain_p})
                 * $signed({{(PROD_W-ERR_W){error_in[ERR_W-1]}}, error_in});
   assign i_prod = $signed({{(PROD_W-GAIN_W){1'b0}}, cfg.gain_i})
                 * $signed({{(PROD_W-ERR_W){int_clamped[ERR_W-1]}}, int_clamped});
   assign d_prod = $signed({{(PROD_W-GAIN_W){1'b0}}, cfg.gain_d})
                 * $signed({{(PROD_W-INT_SUM_W){err_diff[INT_SUM_W-1]}}, err_diff});

   // Dropping the low eight bits of a two's complement product rounds toward minus infinity.
   assign pid_sum = {{2{p_prod[PROD_W-1]}}, p_prod[PROD_W-1:8]}
                  + {{2{i_prod[PROD_W-1]}}, i_prod[PROD_W-1:8]}
                  + {{2{d_prod[PROD_W-1]}}, d_prod[PROD_W-1:8]};

   assign olim_pos = {{(SUM_W-OLIM_W){1'b0}}, cfg.output_limit};
   assign olim_neg = -olim_pos;

   always_comb begin
      if (pid_sum > olim_pos) begin
         drive_clamped = olim_pos[DRIVE_W-1:0];
      end else if (pid_sum < olim_neg) begin
         drive_clamped = olim_neg[DRIVE_W-1:0];
      end else begin
         drive_clamped = pid_sum[DRIVE_W-1:0];
      end
   end

   always_comb begin
      state_nxt = state_cur;
      case (mode_type'(mode))
         MODE_STEP: begin
            state_nxt.integral   = int_clamped;
            state_nxt.last_error = error_in;
            state_nxt.drive      = drive_clamped;
         end
         MODE_CLEAR: begin
            state_nxt.integral   = '0;
            state_nxt.last_error = '0;
            state_nxt.drive      = '0;
         end
         MODE_PRESET: begin
            state_nxt.integral   = '0;
            state_nxt.last_error = error_in;
            state_nxt.drive      = preset_drive;
         end
         default: begin
            state_nxt = state_cur;
         end
      endcase
   end

endmodule
`default_nettype wire

[src/pid_controller_clamped.sv]
// Throughput: one item per cycle unless a valid result waits on rsp_ready.
// The input register and the result register form a two-stage pipeline; the
// controller state is updated in the same cycle as the result register loads.
// Reset (synchronous, active high) clears both pipeline stages, the integral,
// previous error and drive, and loads the gain and limit registers with defaults.
`timescale 1ns / 1ps
`default_nettype none
module pid_controller_clamped (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [pcc_pkg::MODE_W-1:0]          req_mode,
   input  wire logic signed [pcc_pkg::ERR_W-1:0]    req_error_in,
   input  wire logic signed [pcc_pkg::DRIVE_W-1:0]  req_preset_drive,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic signed [pcc_pkg::DRIVE_W-1:0]       rsp_drive,
   input  wire logic                                csr_we,
   input  wire logic [pcc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [pcc_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import pcc_pkg::*;

   cfg_type                   cfg_ff;
   cfg_type                   cfg_in;
   pid_state_type             state_ff;
   pid_state_type             state_in;
   logic                      in_vld_ff;
   logic                      in_vld_in;
   logic [MODE_W-1:0]         mode_ff;
   logic signed [ERR_W-1:0]   error_ff;
   logic signed [DRIVE_W-1:0] preset_ff;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   logic signed [DRIVE_W-1:0] rsp_drive_ff;
   logic                      advance;
   logic                      req_take;

   assign advance   = in_vld_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_vld_ff || advance;
   assign req_take  = req_valid && req_ready;

   assign in_vld_in    = req_take || (in_vld_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_drive = rsp_drive_ff;

   pcc_step u_step (
      .mode         (mode_ff),
      .error_in     (error_ff),
      .preset_drive (preset_ff),
      .cfg          (cfg_ff),
      .state_cur    (state_ff),
      .state_nxt    (state_in)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_GAIN_P:         cfg_in.gain_p         = csr_wdata[GAIN_W-1:0];
            CSR_GAIN_I:         cfg_in.gain_i         = csr_wdata[GAIN_W-1:0];
            CSR_GAIN_D:         cfg_in.gain_d         = csr_wdata[GAIN_W-1:0];
            CSR_INTEGRAL_LIMIT: cfg_in.integral_limit = csr_wdata[ILIM_W-1:0];
            CSR_OUTPUT_LIMIT:   cfg_in.output_limit   = csr_wdata[OLIM_W-1:0];
            default:            cfg_in                = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_p         <= GAIN_P_RESET;
         cfg_ff.gain_i         <= GAIN_I_RESET;
         cfg_ff.gain_d         <= GAIN_D_RESET;
         cfg_ff.integral_limit <= INTEGRAL_LIMIT_RESET;
         cfg_ff.output_limit   <= OUTPUT_LIMIT_RESET;
         state_ff              <= '0;
         in_vld_ff             <= 1'b0;
         rsp_valid_ff          <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         in_vld_ff    <= in_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         mode_ff   <= req_mode;
         error_ff  <= req_error_in;
         preset_ff <= req_preset_drive;
      end
      if (advance) begin
         rsp_drive_ff <= state_in.drive;
      end
   end

endmodule
`default_nettype wire

[src/pcc_checker.sv]
// Port-level checker for the clamped PID controller and its bind statement.
`timescale 1ns / 1ps
`default_nettype none
`include "pid_controller_clamped_defines.svh"
module pcc_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_valid,
   input wire logic                                req_ready,
   input wire logic [pcc_pkg::MODE_W-1:0]          req_mode,
   input wire logic signed [pcc_pkg::DRIVE_W-1:0]  req_preset_drive,
   input wire logic                                rsp_valid,
   input wire logic                                rsp_ready,
   input wire logic signed [pcc_pkg::DRIVE_W-1:0]  rsp_drive
);
   import pcc_pkg::*;

   // A stalled result keeps its value.
   `PCC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_drive), "stalled result changed")

   // The input side only stalls when both pipeline stages hold an item.
   `PCC_ASSERT_SAME(a_ready_full, !req_ready, rsp_valid && !rsp_ready, "input stalled with room in the pipeline")

   // A clear item, followed by rsp_ready, yields a valid zero drive.
   `PCC_ASSERT_NEXT(a_clear_zero, (req_valid && req_ready && req_mode == MODE_CLEAR) ##1 rsp_ready, rsp_valid && rsp_drive == '0, "clear item did not give zero drive")

   // A preset item returns its preset drive unclamped.
   `PCC_ASSERT_NEXT(a_preset_drive, (req_valid && req_ready && req_mode == MODE_PRESET) ##1 rsp_ready, rsp_valid && rsp_drive == $past(req_preset_drive, 2), "preset drive not returned")

   // No result is shown right after reset.
   `PCC_ASSERT_SAME(a_reset_empty, $past(reset), !rsp_valid, "result valid right after reset")

endmodule

bind pid_controller_clamped pcc_checker u_pcc_checker (.*);
`default_nettype wire
